// ===== sv/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb_pkg
// Types, constants and the [1,2,1]/4 tap shared by the blur modules.
// ----------------------------------------------------------------------------
package sgb_pkg;

  typedef logic [7:0]  pix_t;
  typedef logic [11:0] row_t;
  typedef logic [9:0]  col_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  // One word of the line store: the row before last and the last row.
  typedef struct packed {
    rgb_t older;
    rgb_t prev;
  } line_t;

  // Vertical pass output of one request, with its position flags.
  typedef struct packed {
    rgb_t vmain;
    rgb_t vbot;
    row_t row;
    col_t col;
    logic has_up;
    logic last_row;
    logic last_col;
    logic has_left;
    logic has_left2;
  } vitem_t;

  typedef struct packed {
    rgb_t pix;
    row_t row;
    col_t col;
    logic last;
  } result_t;

  // Result slots of one request, in output order.
  localparam int SLOT_MAIN_LEFT = 0;
  localparam int SLOT_MAIN_SELF = 1;
  localparam int SLOT_BOT_LEFT  = 2;
  localparam int SLOT_BOT_SELF  = 3;
  localparam int SLOTS          = 4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  function automatic pix_t tap3(pix_t a, pix_t b, pix_t c);
    logic [9:0] s;
    s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    return s[9:2];
  endfunction

  function automatic rgb_t tap3_rgb(rgb_t a, rgb_t b, rgb_t c);
    rgb_t t;
    t.red   = tap3(a.red, b.red, c.red);
    t.green = tap3(a.green, b.green, c.green);
    t.blue  = tap3(a.blue, b.blue, c.blue);
    return t;
  endfunction

endpackage

// ===== sv/sgb_queue.sv =====
// ----------------------------------------------------------------------------
// sgb_queue
// Small synchronous FIFO built from registers.
// ----------------------------------------------------------------------------
module sgb_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= din;
    end
  end

endmodule

// ===== sv/sgb_front.sv =====
// ----------------------------------------------------------------------------
// sgb_front
// Accepts pixels, tracks the raster position, reads and updates the line
// store and computes the vertical pass for the main and bottom rows.
// ----------------------------------------------------------------------------
module sgb_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 restart,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   wlast,
  input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] hlast,
  input  logic                 push,
  input  sgb_pkg::rgb_t        in_pix,
  output logic                 full,
  output logic                 q_push,
  output sgb_pkg::vitem_t      q_item,
  input  logic                 q_full
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  sgb_pkg::line_t mem [MAX_WIDTH];
  sgb_pkg::line_t rd_r, wdata;

  logic [XW-1:0] x_r, s1_x_r;
  logic [YW-1:0] y_r, s1_y_r;
  logic          s1_valid_r;
  sgb_pkg::rgb_t s1_cur_r;
  logic          s1_up_r, s1_up2_r, s1_lrow_r, s1_lcol_r, s1_left_r, s1_left2_r;
  logic          accept, s1_adv, last_col, last_row;
  sgb_pkg::rgb_t top;

  assign s1_adv   = s1_valid_r & ~q_full;
  assign full     = s1_valid_r & ~s1_adv;
  assign accept   = push & ~full;
  assign last_col = (x_r == wlast);
  assign last_row = (y_r == hlast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      x_r        <= '0;
      y_r        <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (restart) begin
        x_r <= '0;
        y_r <= '0;
      end else if (accept) begin
        if (last_col) begin
          x_r <= '0;
          y_r <= last_row ? '0 : y_r + YW'(1);
        end else begin
          x_r <= x_r + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r   <= in_pix;
      s1_x_r     <= x_r;
      s1_y_r     <= y_r;
      s1_up_r    <= (y_r != '0);
      s1_up2_r   <= (y_r > YW'(1));
      s1_lrow_r  <= last_row;
      s1_lcol_r  <= last_col;
      s1_left_r  <= (x_r != '0);
      s1_left2_r <= (x_r > XW'(1));
    end
  end

  assign wdata.older = rd_r.prev;
  assign wdata.prev  = s1_cur_r;

  // A one-pixel-wide frame reads the column that the request ahead writes in
  // the same cycle, so that word is forwarded.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem[s1_x_r] <= wdata;
    end
    if (accept) begin
      if (s1_adv && (s1_x_r == x_r)) begin
        rd_r <= wdata;
      end else begin
        rd_r <= mem[x_r];
      end
    end
  end

  assign top = s1_up2_r ? rd_r.older : rd_r.prev;

  always_comb begin
    q_item.vmain     = sgb_pkg::tap3_rgb(top, rd_r.prev, s1_cur_r);
    q_item.vbot      = sgb_pkg::tap3_rgb(s1_up_r ? rd_r.prev : s1_cur_r, s1_cur_r, s1_cur_r);
    q_item.row       = sgb_pkg::row_t'(s1_y_r);
    q_item.col       = sgb_pkg::col_t'(s1_x_r);
    q_item.has_up    = s1_up_r;
    q_item.last_row  = s1_lrow_r;
    q_item.last_col  = s1_lcol_r;
    q_item.has_left  = s1_left_r;
    q_item.has_left2 = s1_left2_r;
  end

  assign q_push = s1_adv;

endmodule

// ===== sv/sgb_back.sv =====
// ----------------------------------------------------------------------------
// sgb_back
// Horizontal pass: expands each vertical request into its zero to four
// results, one per cycle while the result queue has room, and keeps the
// column history of both rows.
module sgb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sgb_pkg::vitem_t   vq_item,
  input  logic              vq_empty,
  output logic              vq_pop,
  output logic              oq_push,
  output sgb_pkg::result_t  oq_data,
  input  logic              oq_full
);

  logic [sgb_pkg::SLOTS-1:0] done_r, want, rem, sel, rest;
  sgb_pkg::rgb_t hm0_r, hm1_r, hb0_r, hb1_r;
  sgb_pkg::rgb_t h0, h1, v;
  logic          is_main, is_left, emit, finish;

  always_comb begin
    want = '0;
    want[sgb_pkg::SLOT_MAIN_LEFT] = vq_item.has_up & vq_item.has_left;
    want[sgb_pkg::SLOT_MAIN_SELF] = vq_item.has_up & vq_item.last_col;
    want[sgb_pkg::SLOT_BOT_LEFT]  = vq_item.last_row & vq_item.has_left;
    want[sgb_pkg::SLOT_BOT_SELF]  = vq_item.last_row & vq_item.last_col;
    rem  = want & ~done_r;
    sel  = rem & (~rem + 4'd1);
    rest = rem & ~sel;
  end

  assign is_main = sel[sgb_pkg::SLOT_MAIN_LEFT] | sel[sgb_pkg::SLOT_MAIN_SELF];
  assign is_left = sel[sgb_pkg::SLOT_MAIN_LEFT] | sel[sgb_pkg::SLOT_BOT_LEFT];
  assign emit    = ~vq_empty & (rem != '0) & ~oq_full;
  assign finish  = ~vq_empty & ((rem == '0) | (emit & (rest == '0)));
  assign vq_pop  = finish;
  assign oq_push = emit;

  assign h0 = is_main ? hm0_r : hb0_r;
  assign h1 = is_main ? hm1_r : hb1_r;
  assign v  = is_main ? vq_item.vmain : vq_item.vbot;

  always_comb begin
    if (is_left) begin
      oq_data.pix = sgb_pkg::tap3_rgb(vq_item.has_left2 ? h0 : h1, h1, v);
      oq_data.col = vq_item.col - sgb_pkg::col_t'(1);
    end else begin
      oq_data.pix = sgb_pkg::tap3_rgb(vq_item.has_left ? h1 : v, v, v);
      oq_data.col = vq_item.col;
    end
    oq_data.row  = is_main ? vq_item.row - sgb_pkg::row_t'(1) : vq_item.row;
    oq_data.last = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else if (finish) begin
      done_r <= '0;
    end else if (emit) begin
      done_r <= done_r | sel;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && vq_item.has_up) begin
      hm0_r <= hm1_r;
      hm1_r <= vq_item.vmain;
    end
    if (finish && vq_item.last_row) begin
      hb0_r <= hb1_r;
      hb1_r <= vq_item.vbot;
    end
  end

endmodule

// ===== sv/separable_gaussian_blur_rgb.sv =====
// ----------------------------------------------------------------------------
// separable_gaussian_blur_rgb
// Streaming 3x3 [1,2,1]/4 blur of RGB pixels with replicated edges.
//
//   channel  direction  handshake           payload
//   input    in         push / full         in_red, in_green, in_blue
//   result   out        pop / empty         out_red .. out_last_of_run
//   config   in/out     psel, penable, ...  image_width, image_height
//
// A pixel is accepted every cycle as long as each pixel gives at most one
// result and the result queue has room; a pixel that gives more results holds
// the horizontal unit until all of them are emitted. Reset clears the raster
// position and loads 640 x 480; the line store is not cleared. full rises when
// the vertical stage cannot hand off to its queue.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [11:0] out_row,
  output logic [9:0]  out_column,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int VW = $bits(sgb_pkg::vitem_t);
  localparam int RW = $bits(sgb_pkg::result_t);

  logic [10:0]      width_r;
  logic [12:0]      height_r;
  logic             cfg_wr;
  logic [31:0]      w_ext, h_ext, w_eff, h_eff;
  logic [XW-1:0]    wlast;
  logic [YW-1:0]    hlast;
  sgb_pkg::rgb_t    in_pix;
  logic             vq_push, vq_full, vq_pop, vq_empty;
  sgb_pkg::vitem_t  vq_din, vq_dout;
  logic             oq_push, oq_full;
  sgb_pkg::result_t oq_din, oq_dout;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sgb_pkg::WIDTH_RST;
      height_r <= sgb_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        sgb_pkg::REG_WIDTH:  width_r  <= pwdata[10:0];
        sgb_pkg::REG_HEIGHT: height_r <= pwdata[12:0];
        default:             width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sgb_pkg::REG_WIDTH:  prdata = 32'(width_r);
      sgb_pkg::REG_HEIGHT: prdata = 32'(height_r);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    w_ext = 32'(width_r);
    h_ext = 32'(height_r);
    if (w_ext == '0) begin
      w_eff = 32'd1;
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = 32'd1;
    end else if (h_ext > 32'(MAX_HEIGHT)) begin
      h_eff = 32'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    wlast = XW'(w_eff - 32'd1);
    hlast = YW'(h_eff - 32'd1);
  end

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;

  sgb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr),
    .wlast   (wlast),
    .hlast   (hlast),
    .push    (push),
    .in_pix  (in_pix),
    .full    (full),
    .q_push  (vq_push),
    .q_item  (vq_din),
    .q_full  (vq_full)
  );

  sgb_queue #(
    .W     (VW),
    .DEPTH (2)
  ) u_vq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (vq_push),
    .din   (vq_din),
    .full  (vq_full),
    .pop   (vq_pop),
    .dout  (vq_dout),
    .empty (vq_empty)
  );

  sgb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .vq_item  (vq_dout),
    .vq_empty (vq_empty),
    .vq_pop   (vq_pop),
    .oq_push  (oq_push),
    .oq_data  (oq_din),
    .oq_full  (oq_full)
  );

  sgb_queue #(
    .W     (RW),
    .DEPTH (2)
  ) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_din),
    .full  (oq_full),
    .pop   (pop),
    .dout  (oq_dout),
    .empty (empty)
  );

  assign out_red         = oq_dout.pix.red;
  assign out_green       = oq_dout.pix.green;
  assign out_blue        = oq_dout.pix.blue;
  assign out_row         = oq_dout.row;
  assign out_column      = oq_dout.col;
  assign out_last_of_run = oq_dout.last;

  a_vq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    vq_full |-> !vq_push)
    else $error("vertical queue written while full");

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_full |-> !oq_push)
    else $error("result queue written while full");

  a_vq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    vq_pop |-> !vq_empty)
    else $error("vertical queue read while empty");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming RGB [1,2,1]/4 blur. A driver and a
// monitor run as clocked processes around the block. An in-bench predictor
// keeps its own line buffers, filter history and raster position, and it works
// out the filtered pixels that each accepted request must produce. Frame sizes
// are changed through the APB port between phases. The sizes run from the
// single pixel up to the clamped extremes, and each register write is read
// back. The output side is stalled at random and once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_W       = 1024;
  localparam int MAX_H       = 4096;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [11:0] out_row;
  logic [9:0]  out_column;
  logic        out_last_of_run;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  separable_gaussian_blur_rgb #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .empty           (empty),
    .pop             (pop),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_row         (out_row),
    .out_column      (out_column),
    .out_last_of_run (out_last_of_run),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sgb_pkg::rgb_t    pixels_pending[$];
  sgb_pkg::result_t blurred_expected[$];

  logic [10:0]   frame_width_reg = sgb_pkg::WIDTH_RST;
  logic [12:0]   frame_height_reg = sgb_pkg::HEIGHT_RST;
  int            raster_x = 0;
  int            raster_y = 0;
  sgb_pkg::rgb_t line_prev[MAX_W];
  sgb_pkg::rgb_t line_older[MAX_W];
  sgb_pkg::rgb_t vert_hist[2][2];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int frame_settings = 0;
  int cycle_count = 0;

  task automatic report(string msg);
    if (mismatches < 40) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic sgb_pkg::pix_t blend(sgb_pkg::pix_t a, sgb_pkg::pix_t b,
                                          sgb_pkg::pix_t c);
    int sum;
    sum = int'(a) + 2 * int'(b) + int'(c);
    return sgb_pkg::pix_t'(sum >> 2);
  endfunction

  function automatic sgb_pkg::rgb_t blend_rgb(sgb_pkg::rgb_t a, sgb_pkg::rgb_t b,
                                              sgb_pkg::rgb_t c);
    sgb_pkg::rgb_t t;
    t.red   = blend(a.red, b.red, c.red);
    t.green = blend(a.green, b.green, c.green);
    t.blue  = blend(a.blue, b.blue, c.blue);
    return t;
  endfunction

  // Horizontal pass of one output row. The main row uses sel 0 and the
  // bottom row uses sel 1.
  task automatic horizontal_pass(int sel, sgb_pkg::rgb_t v, int r, int x, logic lastx);
    sgb_pkg::rgb_t    left;
    sgb_pkg::result_t e;
    e.last = 1'b0;
    e.row  = sgb_pkg::row_t'(r);
    if (x >= 1) begin
      left = (x >= 2) ? vert_hist[sel][0] : vert_hist[sel][1];
      e.pix = blend_rgb(left, vert_hist[sel][1], v);
      e.col = sgb_pkg::col_t'(x - 1);
      blurred_expected.push_back(e);
    end
    if (lastx) begin
      left = (x >= 1) ? vert_hist[sel][1] : v;
      e.pix = blend_rgb(left, v, v);
      e.col = sgb_pkg::col_t'(x);
      blurred_expected.push_back(e);
    end
    vert_hist[sel][0] = vert_hist[sel][1];
    vert_hist[sel][1] = v;
  endtask

  task automatic predict_pixel(sgb_pkg::rgb_t px);
    int               w;
    int               h;
    int               x;
    int               y;
    int               queued;
    logic             lastx;
    logic             lasty;
    sgb_pkg::rgb_t    prev;
    sgb_pkg::rgb_t    top;
    sgb_pkg::rgb_t    vmain;
    sgb_pkg::rgb_t    vbot;
    sgb_pkg::result_t e;
    w = (frame_width_reg == 0) ? 1 : int'(frame_width_reg);
    if (w > MAX_W) w = MAX_W;
    h = (frame_height_reg == 0) ? 1 : int'(frame_height_reg);
    if (h > MAX_H) h = MAX_H;
    x = (raster_x >= w) ? w - 1 : raster_x;
    y = (raster_y >= h) ? h - 1 : raster_y;
    lastx = (x + 1 >= w);
    lasty = (y + 1 >= h);
    queued = blurred_expected.size();
    prev = line_prev[x];
    top = (y >= 2) ? line_older[x] : prev;
    vmain = blend_rgb(top, prev, px);
    vbot = blend_rgb((y >= 1) ? prev : px, px, px);
    if (y >= 1) horizontal_pass(0, vmain, y - 1, x, lastx);
    if (lasty) horizontal_pass(1, vbot, y, x, lastx);
    if (blurred_expected.size() > queued) begin
      e = blurred_expected.pop_back();
      e.last = 1'b1;
      blurred_expected.push_back(e);
    end
    line_older[x] = line_prev[x];
    line_prev[x] = px;
    if (lastx) begin
      raster_x = 0;
      raster_y = lasty ? 0 : y + 1;
    end else begin
      raster_x = x + 1;
      raster_y = y;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_pixel(pixels_pending[0]);
        void'(pixels_pending.pop_front());
        pixels_sent++;
      end
      if (!(push && full)) begin
        if (pixels_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push     <= 1'b1;
          in_red   <= pixels_pending[0].red;
          in_green <= pixels_pending[0].green;
          in_blue  <= pixels_pending[0].blue;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    sgb_pkg::result_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (blurred_expected.size() == 0) begin
          report($sformatf("result with no request behind it at row %0d column %0d",
                           out_row, out_column));
        end else begin
          want = blurred_expected.pop_front();
          if (out_red !== want.pix.red)
            report($sformatf("red got %0d expected %0d at (%0d,%0d)",
                             out_red, want.pix.red, want.row, want.col));
          if (out_green !== want.pix.green)
            report($sformatf("green got %0d expected %0d at (%0d,%0d)",
                             out_green, want.pix.green, want.row, want.col));
          if (out_blue !== want.pix.blue)
            report($sformatf("blue got %0d expected %0d at (%0d,%0d)",
                             out_blue, want.pix.blue, want.row, want.col));
          if (out_row !== want.row)
            report($sformatf("row got %0d expected %0d", out_row, want.row));
          if (out_column !== want.col)
            report($sformatf("column got %0d expected %0d", out_column, want.col));
          if (out_last_of_run !== want.last)
            report($sformatf("last flag got %0b expected %0b at (%0d,%0d)",
                             out_last_of_run, want.last, want.row, want.col));
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d pixels waiting and %0d results outstanding",
               pixels_pending.size(), blurred_expected.size());
      $display("separable_gaussian_blur_rgb verification failed");
      $finish;
    end
  end

  task automatic apb_access(logic wr, logic idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      if (idx == sgb_pkg::REG_WIDTH) frame_width_reg = wdata[10:0];
      else frame_height_reg = wdata[12:0];
      raster_x = 0;
      raster_y = 0;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(logic idx, logic [31:0] want);
    logic [31:0] rdata;
    logic [31:0] mask;
    mask = (idx == sgb_pkg::REG_WIDTH) ? 32'h7FF : 32'h1FFF;
    apb_access(1'b0, idx, 32'h0, rdata);
    if ((rdata & mask) !== (want & mask))
      report($sformatf("register %0d read %0d expected %0d", idx, rdata & mask,
                       want & mask));
  endtask

  task automatic cfg_write(logic idx, logic [31:0] value);
    logic [31:0] rdata;
    apb_access(1'b1, idx, value, rdata);
    check_reg(idx, value);
  endtask

  task automatic cfg_frame(int w, int h);
    cfg_write(sgb_pkg::REG_WIDTH, w);
    cfg_write(sgb_pkg::REG_HEIGHT, h);
    frame_settings++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pixels_pending.size() != 0 || blurred_expected.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic sgb_pkg::pix_t random_level();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return sgb_pkg::pix_t'($urandom_range(255));
    endcase
  endfunction

  task automatic add_pixel(sgb_pkg::pix_t r, sgb_pkg::pix_t g, sgb_pkg::pix_t b);
    sgb_pkg::rgb_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    pixels_pending.push_back(p);
  endtask

  task automatic run_random(int w, int h, int n, bit stall_output);
    cfg_frame(w, h);
    if (stall_output) hold_trigger++;
    repeat (n) add_pixel(random_level(), random_level(), random_level());
    wait_drained();
  endtask

  initial begin
    int            i;
    sgb_pkg::pix_t v;
    send_idle_pct = 38;
    recv_idle_pct = 58;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_reg(sgb_pkg::REG_WIDTH, 32'(sgb_pkg::WIDTH_RST));
    check_reg(sgb_pkg::REG_HEIGHT, 32'(sgb_pkg::HEIGHT_RST));

    // A zero size acts as a single pixel.
    cfg_frame(0, 0);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd128);
    wait_drained();

    cfg_frame(1, 3);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd1, 8'd254);
    add_pixel(8'd1, 8'd255, 8'd0);
    wait_drained();

    cfg_frame(3, 1);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd255, 8'd0, 8'd255);
    add_pixel(8'd3, 8'd3, 8'd3);
    add_pixel(8'd255, 8'd255, 8'd255);
    wait_drained();

    cfg_frame(2, 2);
    for (i = 0; i < 8; i++) begin
      v = (((i ^ (i >> 1)) & 1) != 0) ? 8'd255 : 8'd0;
      add_pixel(v, ~v, v);
    end
    wait_drained();

    // Stop partway through a frame; the next write must restart it.
    cfg_frame(3, 3);
    for (i = 0; i < 5; i++) add_pixel(random_level(), random_level(), random_level());
    wait_drained();
    cfg_write(sgb_pkg::REG_HEIGHT, 3);

    run_random(4, 3, 50, 1'b0);
    run_random(5, 4, 60, 1'b0);
    send_idle_pct = 58;
    recv_idle_pct = 38;
    run_random(7, 8191, 60, 1'b0);
    // A width above the maximum is clamped to a 1024-pixel row.
    run_random(2047, 0, 70, 1'b1);
    run_random(3, 5, 60, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(1, 1, 30, 1'b0);
    run_random(6, 2, 60, 1'b0);
    run_random(1024, 4096, 40, 1'b0);

    $display("Sent %0d pixels and checked %0d filtered results across %0d frame sizes,",
             pixels_sent, results_seen, frame_settings);
    $display("from a single pixel up to clamped oversize frames, with a long output stall.");
    if (mismatches == 0) begin
      $display("separable_gaussian_blur_rgb verification clean");
    end else begin
      $display("separable_gaussian_blur_rgb verification failed");
    end
    $finish;
  end

endmodule
